### sv/qmr_pkg.sv
package qmr_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;

   localparam int COMP_W   = 16;
   localparam int COMPS    = 4;
   localparam int CMD_W    = 2;
   localparam int REQ_DATA_W = 2 * COMPS * COMP_W;
   localparam int RSP_DATA_W = COMPS * COMP_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PRODUCT = 2'd0,
      CMD_ROTATE  = 2'd1,
      CMD_DOT     = 2'd2
   } cmd_type;

   localparam int IDX_X = 0;
   localparam int IDX_Y = 1;
   localparam int IDX_Z = 2;
   localparam int IDX_W = 3;

endpackage

### sv/quaternion_multiply_rotate.sv
// Streaming quaternion unit in signed fixed point with FRAC_BITS fraction bits. Each request
// beat carries quaternions a and b in tdata and a command in tuser: the Hamilton product a*b,
// the rotation of the vector (b_x, b_y, b_z) by a as a*(v,1)*conj(a) with its vector part
// returned, or the four-term dot product in r_w. Components a command does not produce are zero,
// and the unused command returns an all-zero result. Results are rounded to nearest with ties
// toward plus infinity and saturated to 16 bits; tuser of the response flags any clipping. The
// unit takes one beat per cycle unless a stalled response holds it. It is a five-stage
// pipeline: cross products, first sums, products with conj(a), second sums, and a
// rounding and saturation stage that is the response register. Each stage holds only while the
// stages after it are full and the response is stalled, so a request is taken whenever a bubble
// remains in the pipeline.
module quaternion_multiply_rotate #(
   parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0 up: a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w.
   input  logic [qmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0 up: cmd.
   input  logic [qmr_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0 up: r_x, r_y, r_z, r_w.
   output logic [qmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Fields from bit 0 up: saturated.
   output logic [0:0]                      rsp_tuser
);

   localparam int CW  = qmr_pkg::COMP_W;
   localparam int PW  = 2 * CW;
   localparam int TW  = ((FRAC_BITS + CW > PW) ? FRAC_BITS + CW : PW) + 2;
   localparam int QW  = TW + CW;
   localparam int UW  = QW + 2;
   localparam int RW  = UW + 1;

   localparam logic signed [RW-1:0] ONE_RW    = RW'(1);
   localparam logic signed [RW-1:0] HALF_ONE  = ONE_RW <<< (FRAC_BITS - 1);
   localparam logic signed [RW-1:0] HALF_TWO  = ONE_RW <<< (2 * FRAC_BITS - 1);
   localparam logic signed [RW-1:0] SAT_MAX   = RW'(32767);
   localparam logic signed [RW-1:0] SAT_MIN   = RW'(-32768);

   localparam int X = qmr_pkg::IDX_X;
   localparam int Y = qmr_pkg::IDX_Y;
   localparam int Z = qmr_pkg::IDX_Z;
   localparam int W = qmr_pkg::IDX_W;

   logic en1, en2, en3, en4, en5;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   qmr_pkg::cmd_type         cmd1_ff, cmd2_ff, cmd3_ff, cmd4_ff;
   logic signed [CW-1:0]     a1_ff [4];
   logic signed [CW-1:0]     a2_ff [4];
   logic signed [PW-1:0]     pr1_ff [4][4];
   logic signed [PW-1:0]     pr1_in [4][4];
   logic signed [TW-1:0]     s2_ff [4];
   logic signed [TW-1:0]     s2_in [4];
   logic signed [TW-1:0]     s3_ff [4];
   logic signed [QW-1:0]     q3_ff [3][4];
   logic signed [QW-1:0]     q3_in [3][4];
   logic signed [TW-1:0]     s4_ff [4];
   logic signed [UW-1:0]     u4_ff [3];
   logic signed [UW-1:0]     u4_in [3];
   logic signed [CW-1:0]     r5_ff [4];
   logic signed [CW-1:0]     r5_in [4];
   logic                     sat5_ff, sat5_in;

   logic signed [CW-1:0]     a_req [4];
   logic signed [CW-1:0]     b_req [4];

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_req[i] = req_tdata[CW*i +: CW];
         b_req[i] = req_tdata[CW*(i+4) +: CW];
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pr1_in[i][j] = a_req[i] * b_req[j];
         end
      end
   end

   // The first sums form a*b, a*(v,1) or the dot product from the same cross products.
   always_comb begin
      logic signed [TW-1:0] p [4][4];
      logic signed [TW-1:0] wt [4];
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            p[i][j] = TW'(pr1_ff[i][j]);
         end
         if (cmd1_ff == qmr_pkg::CMD_ROTATE) begin
            wt[i] = TW'(a1_ff[i]) <<< FRAC_BITS;
         end else begin
            wt[i] = p[i][W];
         end
      end
      s2_in[X] = wt[X] + p[W][X] - p[Z][Y] + p[Y][Z];
      s2_in[Y] = wt[Y] + p[Z][X] + p[W][Y] - p[X][Z];
      s2_in[Z] = wt[Z] - p[Y][X] + p[X][Y] + p[W][Z];
      if (cmd1_ff == qmr_pkg::CMD_DOT) begin
         s2_in[W] = p[W][W] + p[X][X] + p[Y][Y] + p[Z][Z];
      end else begin
         s2_in[W] = wt[W] - p[X][X] - p[Y][Y] - p[Z][Z];
      end
   end

   always_comb begin
      q3_in[X][0] = s2_ff[X] * a2_ff[W];
      q3_in[X][1] = s2_ff[W] * a2_ff[X];
      q3_in[X][2] = s2_ff[Z] * a2_ff[Y];
      q3_in[X][3] = s2_ff[Y] * a2_ff[Z];
      q3_in[Y][0] = s2_ff[Y] * a2_ff[W];
      q3_in[Y][1] = s2_ff[Z] * a2_ff[X];
      q3_in[Y][2] = s2_ff[W] * a2_ff[Y];
      q3_in[Y][3] = s2_ff[X] * a2_ff[Z];
      q3_in[Z][0] = s2_ff[Z] * a2_ff[W];
      q3_in[Z][1] = s2_ff[Y] * a2_ff[X];
      q3_in[Z][2] = s2_ff[X] * a2_ff[Y];
      q3_in[Z][3] = s2_ff[W] * a2_ff[Z];
   end

   always_comb begin
      logic signed [UW-1:0] q [3][4];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 4; j++) begin
            q[i][j] = UW'(q3_ff[i][j]);
         end
      end
      u4_in[X] = q[X][0] - q[X][1] + q[X][2] - q[X][3];
      u4_in[Y] = q[Y][0] - q[Y][1] - q[Y][2] + q[Y][3];
      u4_in[Z] = q[Z][0] + q[Z][1] - q[Z][2] - q[Z][3];
   end

   always_comb begin
      logic signed [RW-1:0] sh_one [4];
      logic signed [RW-1:0] sh_two [3];
      logic signed [RW-1:0] val [4];
      logic                 use_comp [4];
      sat5_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sh_one[i] = (RW'(s4_ff[i]) + HALF_ONE) >>> FRAC_BITS;
      end
      for (int i = 0; i < 3; i++) begin
         sh_two[i] = (RW'(u4_ff[i]) + HALF_TWO) >>> (2 * FRAC_BITS);
      end
      for (int i = 0; i < 4; i++) begin
         case (cmd4_ff)
            qmr_pkg::CMD_PRODUCT: begin
               val[i]      = sh_one[i];
               use_comp[i] = 1'b1;
            end
            qmr_pkg::CMD_ROTATE: begin
               val[i]      = (i < 3) ? sh_two[i % 3] : '0;
               use_comp[i] = (i < 3);
            end
            qmr_pkg::CMD_DOT: begin
               val[i]      = sh_one[i];
               use_comp[i] = (i == W);
            end
            default: begin
               val[i]      = '0;
               use_comp[i] = 1'b0;
            end
         endcase
         if (!use_comp[i]) begin
            r5_in[i] = '0;
         end else if (val[i] > SAT_MAX) begin
            r5_in[i] = CW'(SAT_MAX);
            sat5_in  = 1'b1;
         end else if (val[i] < SAT_MIN) begin
            r5_in[i] = CW'(SAT_MIN);
            sat5_in  = 1'b1;
         end else begin
            r5_in[i] = CW'(val[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff <= qmr_pkg::cmd_type'(req_tuser);
         a1_ff   <= a_req;
         pr1_ff  <= pr1_in;
      end
      if (en2) begin
         cmd2_ff <= cmd1_ff;
         a2_ff   <= a1_ff;
         s2_ff   <= s2_in;
      end
      if (en3) begin
         cmd3_ff <= cmd2_ff;
         s3_ff   <= s2_ff;
         q3_ff   <= q3_in;
      end
      if (en4) begin
         cmd4_ff <= cmd3_ff;
         s4_ff   <= s3_ff;
         u4_ff   <= u4_in;
      end
      if (en5) begin
         r5_ff   <= r5_in;
         sat5_ff <= sat5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {r5_ff[W], r5_ff[Z], r5_ff[Y], r5_ff[X]};
   assign rsp_tuser  = sat5_ff;

   // A clipped result always leaves at least one component on a rail.
   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         r5_ff[X] == 16'sh7fff || r5_ff[X] == 16'sh8000 ||
         r5_ff[Y] == 16'sh7fff || r5_ff[Y] == 16'sh8000 ||
         r5_ff[Z] == 16'sh7fff || r5_ff[Z] == 16'sh8000 ||
         r5_ff[W] == 16'sh7fff || r5_ff[W] == 16'sh8000)
      else $error("saturation flag without a clipped component");

   // Dot products leave the vector part zero.
   a_dot_vector_zero: assert property (@(posedge clock) disable iff (reset)
      v4_ff && en5 && cmd4_ff == qmr_pkg::CMD_DOT |=>
         rsp_tdata[3*CW-1:0] == '0)
      else $error("dot product with a nonzero vector part");

   // Rotations leave the scalar part zero.
   a_rot_scalar_zero: assert property (@(posedge clock) disable iff (reset)
      v4_ff && en5 && cmd4_ff == qmr_pkg::CMD_ROTATE |=> r5_ff[W] == '0)
      else $error("rotation with a nonzero scalar part");

   // With the response stalled, a request is taken only into a bubble.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tready |-> !(v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("request taken into a full pipeline");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int COMP_W = qmr_pkg::COMP_W;
   localparam int COMPS = qmr_pkg::COMPS;
   localparam int CMD_W = qmr_pkg::CMD_W;
   localparam int FRAC = qmr_pkg::FRAC_BITS_DEFAULT;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint HALF_SQRT2 = 11585;
   localparam longint COMP_MAX = 32767;
   localparam longint COMP_MIN = -32768;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_RANDOM = 1628;
   localparam int DRAIN_EVERY = 400;
   localparam int TAIL_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic [COMPS-1:0][COMP_W-1:0] a;
      logic [COMPS-1:0][COMP_W-1:0] b;
   } quat_op_type;

   typedef struct packed {
      logic [COMPS-1:0][COMP_W-1:0] comp;
      logic                         sat;
   } quat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [qmr_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [qmr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   quat_op_type queued_ops[$];
   quat_result_type predicted_results[$];
   quat_op_type next_op;
   quat_op_type seen_op;
   quat_result_type seen_result;
   quat_result_type want_result;
   string comp_name[COMPS] = '{"r_x", "r_y", "r_z", "r_w"};

   logic req_fire = 1'b0;
   int sent_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int ready_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;

   quaternion_multiply_rotate DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic quat_mul(input longint px, py, pz, pw, qx, qy, qz, qw,
                           output longint rx, ry, rz, rw);
      rx = px * qw + pw * qx - pz * qy + py * qz;
      ry = py * qw + pz * qx + pw * qy - px * qz;
      rz = pz * qw - py * qx + px * qy + pw * qz;
      rw = pw * qw - px * qx - py * qy - pz * qz;
   endtask

   function automatic longint round_half_up(input longint v, input int shift);
      return (v + (longint'(1) << (shift - 1))) >>> shift;
   endfunction

   function automatic logic [COMP_W-1:0] clamp_comp(input longint v);
      if (v > COMP_MAX) begin
         return COMP_MAX[COMP_W-1:0];
      end
      if (v < COMP_MIN) begin
         return COMP_MIN[COMP_W-1:0];
      end
      return v[COMP_W-1:0];
   endfunction

   function automatic bit clips(input longint v);
      return (v > COMP_MAX) || (v < COMP_MIN);
   endfunction

   task automatic predict_quat_result(input quat_op_type op, output quat_result_type res);
      longint ax, ay, az, aw, bx, by, bz, bw;
      longint tx, ty, tz, tw, ux, uy, uz, uw;
      longint rnd[COMPS];
      ax = longint'($signed(op.a[qmr_pkg::IDX_X]));
      ay = longint'($signed(op.a[qmr_pkg::IDX_Y]));
      az = longint'($signed(op.a[qmr_pkg::IDX_Z]));
      aw = longint'($signed(op.a[qmr_pkg::IDX_W]));
      bx = longint'($signed(op.b[qmr_pkg::IDX_X]));
      by = longint'($signed(op.b[qmr_pkg::IDX_Y]));
      bz = longint'($signed(op.b[qmr_pkg::IDX_Z]));
      bw = longint'($signed(op.b[qmr_pkg::IDX_W]));
      for (int i = 0; i < COMPS; i++) begin
         rnd[i] = 0;
      end
      case (op.cmd)
         qmr_pkg::CMD_PRODUCT: begin
            quat_mul(ax, ay, az, aw, bx, by, bz, bw, tx, ty, tz, tw);
            rnd[qmr_pkg::IDX_X] = round_half_up(tx, FRAC);
            rnd[qmr_pkg::IDX_Y] = round_half_up(ty, FRAC);
            rnd[qmr_pkg::IDX_Z] = round_half_up(tz, FRAC);
            rnd[qmr_pkg::IDX_W] = round_half_up(tw, FRAC);
         end
         qmr_pkg::CMD_ROTATE: begin
            quat_mul(ax, ay, az, aw, bx, by, bz, ONE, tx, ty, tz, tw);
            quat_mul(tx, ty, tz, tw, -ax, -ay, -az, aw, ux, uy, uz, uw);
            rnd[qmr_pkg::IDX_X] = round_half_up(ux, 2 * FRAC);
            rnd[qmr_pkg::IDX_Y] = round_half_up(uy, 2 * FRAC);
            rnd[qmr_pkg::IDX_Z] = round_half_up(uz, 2 * FRAC);
         end
         qmr_pkg::CMD_DOT: begin
            rnd[qmr_pkg::IDX_W] = round_half_up(ax * bx + ay * by + az * bz + aw * bw, FRAC);
         end
         default: begin
         end
      endcase
      res = '0;
      for (int i = 0; i < COMPS; i++) begin
         res.comp[i] = clamp_comp(rnd[i]);
         res.sat = res.sat | clips(rnd[i]);
      end
   endtask

   function automatic quat_op_type make_op(input logic [CMD_W-1:0] cmd,
                                           input longint ax, ay, az, aw, bx, by, bz, bw);
      quat_op_type op;
      op.cmd = cmd;
      op.a[qmr_pkg::IDX_X] = ax[COMP_W-1:0];
      op.a[qmr_pkg::IDX_Y] = ay[COMP_W-1:0];
      op.a[qmr_pkg::IDX_Z] = az[COMP_W-1:0];
      op.a[qmr_pkg::IDX_W] = aw[COMP_W-1:0];
      op.b[qmr_pkg::IDX_X] = bx[COMP_W-1:0];
      op.b[qmr_pkg::IDX_Y] = by[COMP_W-1:0];
      op.b[qmr_pkg::IDX_Z] = bz[COMP_W-1:0];
      op.b[qmr_pkg::IDX_W] = bw[COMP_W-1:0];
      return op;
   endfunction

   function automatic logic [COMP_W-1:0] random_comp();
      case ($urandom_range(0, 9))
         0: return COMP_MAX[COMP_W-1:0];
         1: return COMP_MIN[COMP_W-1:0];
         2, 3: return COMP_W'($urandom_range(0, 2 * ONE) - ONE);
         4: return COMP_W'($urandom_range(0, 64) - 32);
         default: return COMP_W'($urandom);
      endcase
   endfunction

   function automatic quat_op_type random_op();
      quat_op_type op;
      int pick;
      pick = $urandom_range(0, 24);
      if (pick == 0) begin
         op.cmd = CMD_UNUSED;
      end else if (pick <= 8) begin
         op.cmd = qmr_pkg::CMD_PRODUCT;
      end else if (pick <= 16) begin
         op.cmd = qmr_pkg::CMD_ROTATE;
      end else begin
         op.cmd = qmr_pkg::CMD_DOT;
      end
      for (int i = 0; i < COMPS; i++) begin
         op.a[i] = random_comp();
         op.b[i] = random_comp();
      end
      return op;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("Mismatch: %s", msg);
      end
   endtask

   // Request driver: bursts of beats separated by gaps, with a full drain at fixed points.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (queued_ops.size() != 0 &&
                      !(sent_count > 0 && sent_count % DRAIN_EVERY == 0 &&
                        predicted_results.size() != 0)) begin
            next_op = queued_ops.pop_front();
            req_tdata <= {next_op.b, next_op.a};
            req_tuser <= next_op.cmd;
            req_tvalid <= 1'b1;
            sent_count <= sent_count + 1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure: a stall followed by a run of ready cycles, sometimes a long one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (ready_left > 0) begin
         rsp_tready <= 1'b1;
         ready_left <= ready_left - 1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
         ready_left <= ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_result.comp = rsp_tdata;
            seen_result.sat = rsp_tuser[0];
            if (predicted_results.size() == 0) begin
               log_mismatch($sformatf("result beat %h with none expected", rsp_tdata));
            end else begin
               want_result = predicted_results.pop_front();
               for (int i = 0; i < COMPS; i++) begin
                  if (seen_result.comp[i] !== want_result.comp[i]) begin
                     log_mismatch($sformatf("%s expected %0d, got %0d", comp_name[i],
                                            $signed(want_result.comp[i]),
                                            $signed(seen_result.comp[i])));
                  end
               end
               if (seen_result.sat !== want_result.sat) begin
                  log_mismatch($sformatf("saturated expected %0b, got %0b",
                                         want_result.sat, seen_result.sat));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen_op.cmd = req_tuser;
            seen_op.a = req_tdata[qmr_pkg::RSP_DATA_W-1:0];
            seen_op.b = req_tdata[qmr_pkg::REQ_DATA_W-1:qmr_pkg::RSP_DATA_W];
            predict_quat_result(seen_op, want_result);
            predicted_results.push_back(want_result);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, 0, 0, 0, ONE, 0, 0, 0, ONE));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, 32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, ONE, 0, 0, 0, 0, ONE, 0, 0));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, 1, 0, 0, 0, 0, 0, 0, ONE / 2));
      queued_ops.push_back(make_op(qmr_pkg::CMD_PRODUCT, -1, 0, 0, 0, 0, 0, 0, ONE / 2));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, 0, 0, 0, ONE,
                                   1000, -2000, 3000, 7));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, 0, 0, HALF_SQRT2, HALF_SQRT2,
                                   ONE, 0, 0, -5));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, 0, 0, 0, 0,
                                   12345, -6789, 32767, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_ROTATE, 32767, -32768, 32767, -32768,
                                   -32768, 32767, -32768, 32767));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, 32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768, -32768));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, 1, 0, 0, 0, ONE / 2, 0, 0, 0));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, -1, 0, 0, 0, ONE / 2, 0, 0, 0));
      queued_ops.push_back(make_op(qmr_pkg::CMD_DOT, 0, 0, 0, ONE, 0, 0, 0, ONE));
      queued_ops.push_back(make_op(CMD_UNUSED, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
      queued_ops.push_back(make_op(CMD_UNUSED, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         queued_ops.push_back(random_op());
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (queued_ops.size() != 0 || req_tvalid);
      while (predicted_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
